### design/ec_point_add_double_top_macros.svh
// Assertion macros shared by the point add/double block.
`ifndef EC_POINT_ADD_DOUBLE_TOP_MACROS_SVH
`define EC_POINT_ADD_DOUBLE_TOP_MACROS_SVH

`ifndef ASSERT_OFF
// Property checked on every clock edge outside reset.
`define EC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Implication checked on every clock edge outside reset.
`define EC_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
// Implication whose consequent is checked in the cycle after the antecedent.
`define EC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define EC_ASSERT(lbl, prop, msg)
`define EC_ASSERT_IMPL(lbl, ante, cons, msg)
`define EC_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

### design/ecpad_pkg.sv
// Package with constants, types and microcode of the point add/double block.
package ecpad_pkg;

    localparam logic [255:0] P =
        256'hFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFEFFFFFC2F;
    localparam logic [255:0] PM2 =
        256'hFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFEFFFFFC2D;
    localparam logic [255:0] FE_ONE = 256'd1;

    // Actions
    localparam logic [2:0] ACT_LOAD = 3'd0;
    localparam logic [2:0] ACT_PADD = 3'd1;
    localparam logic [2:0] ACT_PMIX = 3'd2;
    localparam logic [2:0] ACT_PDBL = 3'd3;
    localparam logic [2:0] ACT_AADD = 3'd4;
    localparam logic [2:0] ACT_ADBL = 3'd5;

    localparam logic [2:0] SLOT_LAST = 3'd5;
    localparam logic [2:0] INIT_ONE  = 3'd6;
    localparam logic [3:0] OUT_LAST_IDX = 4'd11;

    // Work register file addresses
    localparam logic [4:0] R_X1  = 5'd0;
    localparam logic [4:0] R_Y1  = 5'd1;
    localparam logic [4:0] R_Z1  = 5'd2;
    localparam logic [4:0] R_X2  = 5'd3;
    localparam logic [4:0] R_Y2  = 5'd4;
    localparam logic [4:0] R_Z2  = 5'd5;
    localparam logic [4:0] R_ONE = 5'd6;
    localparam logic [4:0] T0  = 5'd8;
    localparam logic [4:0] T1  = 5'd9;
    localparam logic [4:0] T2  = 5'd10;
    localparam logic [4:0] T3  = 5'd11;
    localparam logic [4:0] T4  = 5'd12;
    localparam logic [4:0] T5  = 5'd13;
    localparam logic [4:0] T6  = 5'd14;
    localparam logic [4:0] T7  = 5'd15;
    localparam logic [4:0] T8  = 5'd16;
    localparam logic [4:0] T9  = 5'd17;
    localparam logic [4:0] T10 = 5'd18;
    localparam logic [4:0] T11 = 5'd19;
    localparam logic [4:0] T12 = 5'd20;
    localparam logic [4:0] T13 = 5'd21;
    localparam logic [4:0] T14 = 5'd22;
    localparam logic [4:0] T15 = 5'd23;
    localparam logic [4:0] T16 = 5'd24;
    localparam logic [4:0] T17 = 5'd25;
    localparam logic [4:0] T18 = 5'd26;
    localparam logic [4:0] T19 = 5'd27;
    localparam logic [4:0] R_RX = 5'd29;
    localparam logic [4:0] R_RY = 5'd30;
    localparam logic [4:0] R_RZ = 5'd31;

    // Program start addresses
    localparam logic [6:0] PC_PADD = 7'd0;
    localparam logic [6:0] PC_PMIX = 7'd22;
    localparam logic [6:0] PC_PDBL = 7'd44;
    localparam logic [6:0] PC_AADD = 7'd71;
    localparam logic [6:0] PC_ADBL = 7'd83;

    typedef enum logic [2:0] {
        UOP_END, UOP_ADD, UOP_SUB, UOP_MUL, UOP_INV, UOP_MOV
    } uop_t;

    typedef struct packed {
        uop_t       op;
        logic [4:0] dst;
        logic [4:0] a;
        logic [4:0] b;
    } instr_t;

    typedef enum logic [2:0] {
        WS_INIT, WS_ADD, WS_SUB, WS_MOV, WS_MUL, WS_ACC
    } wsel_t;

    typedef enum logic [1:0] {
        MS_RAM, MS_SQR, MS_BASE
    } msrc_t;

    typedef struct packed {
        logic       load_en;
        logic       init_en;
        logic [2:0] init_idx;
        logic [4:0] rd_a;
        logic [4:0] rd_b;
        logic       wr_en;
        logic [4:0] wr_addr;
        wsel_t      wr_sel;
        logic       mul_start;
        msrc_t      mul_src;
        logic       inv_setup;
        logic       acc_load;
        logic       res_cap;
        logic [1:0] res_idx;
    } dp_cmd_t;

    typedef struct packed {
        logic mul_done;
    } dp_sts_t;

    function automatic instr_t mk(input uop_t op, input logic [4:0] d,
                                  input logic [4:0] a, input logic [4:0] b);
        instr_t r;
        r.op  = op;
        r.dst = d;
        r.a   = a;
        r.b   = b;
        return r;
    endfunction

    function automatic instr_t prog_padd(input logic [4:0] k, input logic [4:0] z2);
        instr_t r;
        unique case (k)
            5'd0:  r = mk(UOP_MUL, T0, R_Y2, R_Z1);
            5'd1:  r = mk(UOP_MUL, T1, R_Y1, z2);
            5'd2:  r = mk(UOP_MUL, T2, R_X2, R_Z1);
            5'd3:  r = mk(UOP_MUL, T3, R_X1, z2);
            5'd4:  r = mk(UOP_SUB, T4, T0, T1);
            5'd5:  r = mk(UOP_SUB, T5, T2, T3);
            5'd6:  r = mk(UOP_MUL, T6, R_Z1, z2);
            5'd7:  r = mk(UOP_MUL, T7, T4, T4);
            5'd8:  r = mk(UOP_MUL, T8, T5, T5);
            5'd9:  r = mk(UOP_MUL, T9, T8, T5);
            5'd10: r = mk(UOP_MUL, T10, T7, T6);
            5'd11: r = mk(UOP_MUL, T11, T8, T3);
            5'd12: r = mk(UOP_SUB, T12, T10, T9);
            5'd13: r = mk(UOP_ADD, T13, T11, T11);
            5'd14: r = mk(UOP_SUB, T14, T12, T13);
            5'd15: r = mk(UOP_MUL, R_RX, T5, T14);
            5'd16: r = mk(UOP_SUB, T12, T11, T14);
            5'd17: r = mk(UOP_MUL, T13, T12, T4);
            5'd18: r = mk(UOP_MUL, T15, T9, T1);
            5'd19: r = mk(UOP_SUB, R_RY, T13, T15);
            5'd20: r = mk(UOP_MUL, R_RZ, T9, T6);
            default: r = mk(UOP_END, R_X1, R_X1, R_X1);
        endcase
        return r;
    endfunction

    function automatic instr_t prog_pdbl(input logic [4:0] k);
        instr_t r;
        unique case (k)
            5'd0:  r = mk(UOP_MUL, T0, R_X1, R_X1);
            5'd1:  r = mk(UOP_ADD, T1, T0, T0);
            5'd2:  r = mk(UOP_ADD, T2, T1, T0);
            5'd3:  r = mk(UOP_MUL, T3, R_Y1, R_Z1);
            5'd4:  r = mk(UOP_MUL, T4, R_Y1, T3);
            5'd5:  r = mk(UOP_MUL, T5, T4, R_X1);
            5'd6:  r = mk(UOP_ADD, T6, T5, T5);
            5'd7:  r = mk(UOP_ADD, T7, T6, T6);
            5'd8:  r = mk(UOP_ADD, T8, T7, T7);
            5'd9:  r = mk(UOP_MUL, T9, T2, T2);
            5'd10: r = mk(UOP_SUB, T10, T9, T8);
            5'd11: r = mk(UOP_MUL, T11, T10, T3);
            5'd12: r = mk(UOP_ADD, R_RX, T11, T11);
            5'd13: r = mk(UOP_MUL, T12, T3, T3);
            5'd14: r = mk(UOP_MUL, T13, R_Y1, R_Y1);
            5'd15: r = mk(UOP_MUL, T14, T13, T12);
            5'd16: r = mk(UOP_ADD, T15, T14, T14);
            5'd17: r = mk(UOP_ADD, T16, T15, T15);
            5'd18: r = mk(UOP_ADD, T17, T16, T16);
            5'd19: r = mk(UOP_SUB, T18, T7, T10);
            5'd20: r = mk(UOP_MUL, T19, T18, T2);
            5'd21: r = mk(UOP_SUB, R_RY, T19, T17);
            5'd22: r = mk(UOP_MUL, T4, T12, T3);
            5'd23: r = mk(UOP_ADD, T5, T4, T4);
            5'd24: r = mk(UOP_ADD, T6, T5, T5);
            5'd25: r = mk(UOP_ADD, R_RZ, T6, T6);
            default: r = mk(UOP_END, R_X1, R_X1, R_X1);
        endcase
        return r;
    endfunction

    function automatic instr_t prog_aadd(input logic [4:0] k);
        instr_t r;
        unique case (k)
            5'd0:  r = mk(UOP_SUB, T0, R_Y2, R_Y1);
            5'd1:  r = mk(UOP_SUB, T1, R_X2, R_X1);
            5'd2:  r = mk(UOP_INV, T2, T1, T1);
            5'd3:  r = mk(UOP_MUL, T3, T0, T2);
            5'd4:  r = mk(UOP_MUL, T4, T3, T3);
            5'd5:  r = mk(UOP_SUB, T5, T4, R_X1);
            5'd6:  r = mk(UOP_SUB, R_RX, T5, R_X2);
            5'd7:  r = mk(UOP_SUB, T6, R_X2, R_RX);
            5'd8:  r = mk(UOP_MUL, T7, T6, T3);
            5'd9:  r = mk(UOP_SUB, R_RY, T7, R_Y2);
            5'd10: r = mk(UOP_MOV, R_RZ, R_ONE, R_ONE);
            default: r = mk(UOP_END, R_X1, R_X1, R_X1);
        endcase
        return r;
    endfunction

    function automatic instr_t prog_adbl(input logic [4:0] k);
        instr_t r;
        unique case (k)
            5'd0:  r = mk(UOP_MUL, T0, R_X1, R_X1);
            5'd1:  r = mk(UOP_ADD, T1, T0, T0);
            5'd2:  r = mk(UOP_ADD, T2, T1, T0);
            5'd3:  r = mk(UOP_ADD, T3, R_Y1, R_Y1);
            5'd4:  r = mk(UOP_INV, T4, T3, T3);
            5'd5:  r = mk(UOP_MUL, T5, T2, T4);
            5'd6:  r = mk(UOP_MUL, T6, T5, T5);
            5'd7:  r = mk(UOP_ADD, T7, R_X1, R_X1);
            5'd8:  r = mk(UOP_SUB, R_RX, T6, T7);
            5'd9:  r = mk(UOP_SUB, T8, R_X1, R_RX);
            5'd10: r = mk(UOP_MUL, T9, T8, T5);
            5'd11: r = mk(UOP_SUB, R_RY, T9, R_Y1);
            5'd12: r = mk(UOP_MOV, R_RZ, R_ONE, R_ONE);
            default: r = mk(UOP_END, R_X1, R_X1, R_X1);
        endcase
        return r;
    endfunction

    function automatic instr_t ucode(input logic [6:0] pc);
        instr_t r;
        if (pc < PC_PMIX)
            r = prog_padd(pc[4:0], R_Z2);
        else if (pc < PC_PDBL)
            r = prog_padd(5'(pc - PC_PMIX), R_ONE);
        else if (pc < PC_AADD)
            r = prog_pdbl(5'(pc - PC_PDBL));
        else if (pc < PC_ADBL)
            r = prog_aadd(5'(pc - PC_AADD));
        else
            r = prog_adbl(5'(pc - PC_ADBL));
        return r;
    endfunction

    function automatic logic [6:0] start_pc(input logic [2:0] act);
        logic [6:0] r;
        unique case (act)
            ACT_PADD: r = PC_PADD;
            ACT_PMIX: r = PC_PMIX;
            ACT_PDBL: r = PC_PDBL;
            ACT_AADD: r = PC_AADD;
            default:  r = PC_ADBL;
        endcase
        return r;
    endfunction

endpackage

### design/ecpad_ram.sv
// Generic RAM: one write port, two registered read ports.
module ecpad_ram
    #(
    parameter int WIDTH = 256,
    parameter int DEPTH = 32
    )
    (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_a,
    output logic [WIDTH-1:0]         rdata_b
    );

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

### design/ecpad_modmul.sv
// Bit-serial modular multiplier over the secp256k1 prime, one bit per cycle.
module ecpad_modmul
    import ecpad_pkg::*;
    (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [255:0] a,
    input  logic [255:0] b,
    output logic         done,
    output logic [255:0] result
    );

    logic [255:0] a_reg, b_reg, r_reg;
    logic [7:0]   cnt_reg;
    logic         busy_reg, done_reg;
    logic [257:0] t;
    logic [258:0] d1, d2;
    logic [255:0] r_next;

    always_comb
    begin
        t  = {1'b0, r_reg, 1'b0} + {2'b00, (b_reg[255] ? a_reg : 256'd0)};
        d1 = {1'b0, t} - {3'b000, P};
        d2 = {1'b0, t} - {2'b00, P, 1'b0};
        // t stays below 3p: subtract p once or twice
        if (!d2[258])
            r_next = d2[255:0];
        else if (!d1[258])
            r_next = d1[255:0];
        else
            r_next = t[255:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 8'd1;
                if (cnt_reg == 8'd255)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg <= a;
            b_reg <= b;
            r_reg <= '0;
        end
        else if (busy_reg)
        begin
            b_reg <= {b_reg[254:0], 1'b0};
            r_reg <= r_next;
        end
    end

    assign done   = done_reg;
    assign result = r_reg;

endmodule

### design/ecpad_datapath.sv
// Datapath: operand store, work register file, field ALU, multiplier, result store.
module ecpad_datapath
    import ecpad_pkg::*;
    #(
    parameter int LIMB_WIDTH = 64
    )
    (
    input  logic         clk,
    input  logic         rst_n,
    input  dp_cmd_t      cmd,
    output dp_sts_t      sts,
    input  logic [2:0]   load_slot,
    input  logic [1:0]   load_limb,
    input  logic [63:0]  load_value,
    input  logic [3:0]   out_idx,
    output logic [1:0]   out_coord,
    output logic [1:0]   out_limb,
    output logic [63:0]  out_value
    );

    localparam logic [63:0] LIMB_MASK =
        (LIMB_WIDTH >= 64) ? 64'hFFFF_FFFF_FFFF_FFFF : ((64'd1 << LIMB_WIDTH) - 64'd1);

    logic [255:0] op_reg [6];
    logic [255:0] res_reg [3];
    logic [255:0] acc_reg, base_reg;
    logic [255:0] rdata_a, rdata_b, wdata, init_val;
    logic [255:0] mul_a, mul_b, mul_res, res_sel;
    logic         mul_done;

    function automatic logic [255:0] add_mod(input logic [255:0] x, input logic [255:0] y);
        logic [256:0] s;
        logic [257:0] d;
        s = {1'b0, x} + {1'b0, y};
        d = {1'b0, s} - {2'b00, P};
        return d[257] ? s[255:0] : d[255:0];
    endfunction

    function automatic logic [255:0] sub_mod(input logic [255:0] x, input logic [255:0] y);
        logic [256:0] d;
        d = {1'b0, x} - {1'b0, y};
        return d[256] ? (d[255:0] + P) : d[255:0];
    endfunction

    function automatic logic [255:0] norm(input logic [255:0] x);
        logic [256:0] d;
        d = {1'b0, x} - {1'b0, P};
        return d[256] ? x : d[255:0];
    endfunction

    // Operand store, written one limb per transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 6; i++)
            begin
                op_reg[i] <= '0;
            end
        end
        else if (cmd.load_en && (load_slot <= SLOT_LAST))
        begin
            op_reg[load_slot][{load_limb, 6'b000000} +: 64] <= load_value & LIMB_MASK;
        end
    end

    always_comb
    begin
        if (cmd.init_idx <= SLOT_LAST)
            init_val = norm(op_reg[cmd.init_idx]);
        else
            init_val = FE_ONE;
    end

    always_comb
    begin
        case (cmd.wr_sel)
            WS_INIT: wdata = init_val;
            WS_ADD:  wdata = add_mod(rdata_a, rdata_b);
            WS_SUB:  wdata = sub_mod(rdata_a, rdata_b);
            WS_MOV:  wdata = rdata_a;
            WS_MUL:  wdata = mul_res;
            default: wdata = acc_reg;
        endcase
    end

    ecpad_ram #(.WIDTH(256), .DEPTH(32)) u_regfile (
        .clk     (clk),
        .we      (cmd.wr_en),
        .waddr   (cmd.wr_addr),
        .wdata   (wdata),
        .raddr_a (cmd.rd_a),
        .raddr_b (cmd.rd_b),
        .rdata_a (rdata_a),
        .rdata_b (rdata_b)
    );

    always_comb
    begin
        case (cmd.mul_src)
            MS_SQR:
            begin
                mul_a = acc_reg;
                mul_b = acc_reg;
            end
            MS_BASE:
            begin
                mul_a = acc_reg;
                mul_b = base_reg;
            end
            default:
            begin
                mul_a = rdata_a;
                mul_b = rdata_b;
            end
        endcase
    end

    ecpad_modmul u_mul (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (cmd.mul_start),
        .a      (mul_a),
        .b      (mul_b),
        .done   (mul_done),
        .result (mul_res)
    );

    assign sts.mul_done = mul_done;

    // Inversion accumulator and base
    always_ff @(posedge clk)
    begin
        if (cmd.inv_setup)
        begin
            base_reg <= rdata_a;
            acc_reg  <= FE_ONE;
        end
        else if (cmd.acc_load)
        begin
            acc_reg <= mul_res;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.res_cap)
        begin
            case (cmd.res_idx)
                2'd0:    res_reg[0] <= rdata_a;
                2'd1:    res_reg[1] <= rdata_a;
                default: res_reg[2] <= rdata_a;
            endcase
        end
    end

    always_comb
    begin
        case (out_idx[3:2])
            2'd0:    res_sel = res_reg[0];
            2'd1:    res_sel = res_reg[1];
            2'd2:    res_sel = res_reg[2];
            default: res_sel = '0;
        endcase
    end

    assign out_coord = out_idx[3:2];
    assign out_limb  = out_idx[1:0];
    assign out_value = res_sel[{out_idx[1:0], 6'b000000} +: 64] & LIMB_MASK;

endmodule

### design/ecpad_ctrl.sv
// Controller: microcode sequencer, inversion loop and result streaming.
`include "ec_point_add_double_top_macros.svh"
module ecpad_ctrl
    import ecpad_pkg::*;
    (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic [2:0] in_action,
    output logic       in_ready,
    output logic       out_valid,
    input  logic       out_ready,
    output logic       out_last,
    output logic [3:0] out_idx,
    output dp_cmd_t    cmd,
    input  dp_sts_t    sts
    );

    typedef enum logic [9:0] {
        S_IDLE   = 10'b0000000001,
        S_INIT   = 10'b0000000010,
        S_FETCH  = 10'b0000000100,
        S_EXEC   = 10'b0000001000,
        S_MWAIT  = 10'b0000010000,
        S_ISTART = 10'b0000100000,
        S_IWAIT  = 10'b0001000000,
        S_IWRITE = 10'b0010000000,
        S_COPY   = 10'b0100000000,
        S_DRAIN  = 10'b1000000000
    } state_t;

    state_t     state_reg, state_next;
    logic [6:0] pc_reg, pc_next;
    logic [2:0] init_reg, init_next;
    logic [7:0] bit_reg, bit_next;
    logic       mulb_reg, mulb_next;
    logic [1:0] copy_reg, copy_next;
    logic [3:0] oidx_reg, oidx_next;
    instr_t     ins;

    assign ins = ucode(pc_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            pc_reg    <= '0;
            init_reg  <= '0;
            bit_reg   <= '0;
            mulb_reg  <= 1'b0;
            copy_reg  <= '0;
            oidx_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            pc_reg    <= pc_next;
            init_reg  <= init_next;
            bit_reg   <= bit_next;
            mulb_reg  <= mulb_next;
            copy_reg  <= copy_next;
            oidx_reg  <= oidx_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        pc_next    = pc_reg;
        init_next  = init_reg;
        bit_next   = bit_reg;
        mulb_next  = mulb_reg;
        copy_next  = copy_reg;
        oidx_next  = oidx_reg;
        cmd           = '0;
        cmd.rd_a      = ins.a;
        cmd.rd_b      = ins.b;
        cmd.wr_addr   = ins.dst;
        cmd.wr_sel    = WS_INIT;
        cmd.mul_src   = MS_RAM;
        cmd.init_idx  = init_reg;
        in_ready  = 1'b0;
        out_valid = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    case (in_action) inside
                        ACT_LOAD:
                        begin
                            cmd.load_en = 1'b1;
                        end
                        ACT_PADD, ACT_PMIX, ACT_PDBL, ACT_AADD, ACT_ADBL:
                        begin
                            pc_next    = start_pc(in_action);
                            init_next  = '0;
                            state_next = S_INIT;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_INIT:
            begin
                // copy normalized operands and the constant one into the file
                cmd.init_en = 1'b1;
                cmd.wr_en   = 1'b1;
                cmd.wr_sel  = WS_INIT;
                cmd.wr_addr = {2'b00, init_reg};
                init_next   = init_reg + 3'd1;
                if (init_reg == INIT_ONE)
                    state_next = S_FETCH;
            end
            S_FETCH:
            begin
                if (ins.op == UOP_END)
                begin
                    copy_next  = '0;
                    state_next = S_COPY;
                end
                else
                    state_next = S_EXEC;
            end
            S_EXEC:
            begin
                case (ins.op)
                    UOP_ADD, UOP_SUB, UOP_MOV:
                    begin
                        cmd.wr_en  = 1'b1;
                        cmd.wr_sel = (ins.op == UOP_ADD) ? WS_ADD :
                                     (ins.op == UOP_SUB) ? WS_SUB : WS_MOV;
                        pc_next    = pc_reg + 7'd1;
                        state_next = S_FETCH;
                    end
                    UOP_MUL:
                    begin
                        cmd.mul_start = 1'b1;
                        cmd.mul_src   = MS_RAM;
                        state_next    = S_MWAIT;
                    end
                    UOP_INV:
                    begin
                        cmd.inv_setup = 1'b1;
                        bit_next      = 8'd255;
                        mulb_next     = 1'b0;
                        state_next    = S_ISTART;
                    end
                    default:
                    begin
                        state_next = S_FETCH;
                    end
                endcase
            end
            S_MWAIT:
            begin
                if (sts.mul_done)
                begin
                    cmd.wr_en  = 1'b1;
                    cmd.wr_sel = WS_MUL;
                    pc_next    = pc_reg + 7'd1;
                    state_next = S_FETCH;
                end
            end
            S_ISTART:
            begin
                cmd.mul_start = 1'b1;
                cmd.mul_src   = mulb_reg ? MS_BASE : MS_SQR;
                state_next    = S_IWAIT;
            end
            S_IWAIT:
            begin
                // square, then multiply by the base where the exponent bit is set
                if (sts.mul_done)
                begin
                    cmd.acc_load = 1'b1;
                    if (!mulb_reg && PM2[bit_reg])
                    begin
                        mulb_next  = 1'b1;
                        state_next = S_ISTART;
                    end
                    else if (bit_reg == 8'd0)
                        state_next = S_IWRITE;
                    else
                    begin
                        bit_next   = bit_reg - 8'd1;
                        mulb_next  = 1'b0;
                        state_next = S_ISTART;
                    end
                end
            end
            S_IWRITE:
            begin
                cmd.wr_en  = 1'b1;
                cmd.wr_sel = WS_ACC;
                pc_next    = pc_reg + 7'd1;
                state_next = S_FETCH;
            end
            S_COPY:
            begin
                cmd.rd_a  = R_RX + {3'b000, copy_reg};
                copy_next = copy_reg + 2'd1;
                if (copy_reg != 2'd0)
                begin
                    cmd.res_cap = 1'b1;
                    cmd.res_idx = copy_reg - 2'd1;
                end
                if (copy_reg == 2'd3)
                begin
                    oidx_next  = '0;
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    oidx_next = oidx_reg + 4'd1;
                    if (oidx_reg == OUT_LAST_IDX)
                        state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign out_idx  = oidx_reg;
    assign out_last = (oidx_reg == OUT_LAST_IDX);

    `EC_ASSERT(a_no_in_during_out, !(in_ready && out_valid), "input taken while draining")
    `EC_ASSERT_IMPL(a_idle_no_write, state_reg == S_IDLE, !cmd.wr_en, "file write while idle")
    `EC_ASSERT_NEXT(a_mul_hold, (state_reg == S_MWAIT) && !sts.mul_done,
                    state_reg == S_MWAIT, "left multiply wait early")
    `EC_ASSERT_NEXT(a_last_idle, out_valid && out_ready && out_last,
                    state_reg == S_IDLE, "no return to idle after last limb")

endmodule

### design/ec_point_add_double_top.sv
// Top level of the secp256k1 point add/double block.
// Usage:
//   Input stream (s_*): one transaction per action. s_tuser carries the action.
//   A load action writes one 64-bit limb of one operand coordinate and makes
//   no output. Actions 1 to 5 run a point operation on the loaded operands;
//   actions 6 and 7 are dropped.
//   Output stream (m_*): each operation returns 12 limb transactions, x, y,
//   then z, least significant limb first; m_tlast marks the twelfth.
// Operations: every field multiply runs on one bit-serial modular multiplier.
//   Projective and mixed add take 14 multiplies; projective double takes 11.
//   Affine modes add an inversion by exponentiation (505 multiplies).
// s_tready is high only while the block is idle; one operation at a time.
// Reset clears the operand store to zero and returns the block to idle.
// A stall on m_tready holds the current limb and the whole block.
module ec_point_add_double_top
    import ecpad_pkg::*;
    #(
    parameter int LIMB_WIDTH = 64
    )
    (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,   // operand_slot[2:0], limb_index[4:3], limb_value[68:5]
    input  logic [2:0]  s_tuser,   // action[2:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,   // limb_index_res[1:0], limb_value_res[65:2]
    output logic [1:0]  m_tuser,   // coordinate[1:0]
    output logic        m_tlast
    );

    dp_cmd_t     cmd;
    dp_sts_t     sts;
    logic [3:0]  out_idx;
    logic [1:0]  out_coord, out_limb;
    logic [63:0] out_value;

    ecpad_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_action (s_tuser),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_last  (m_tlast),
        .out_idx   (out_idx),
        .cmd       (cmd),
        .sts       (sts)
    );

    ecpad_datapath #(.LIMB_WIDTH(LIMB_WIDTH)) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .sts        (sts),
        .load_slot  (s_tdata[2:0]),
        .load_limb  (s_tdata[4:3]),
        .load_value (s_tdata[68:5]),
        .out_idx    (out_idx),
        .out_coord  (out_coord),
        .out_limb   (out_limb),
        .out_value  (out_value)
    );

    assign m_tdata = {6'b000000, out_value, out_limb};
    assign m_tuser = out_coord;

endmodule
